// ===== rtl/core/fcw_pkg.sv =====
// Shared codes, constants and types for the FAT12 cluster chain walker.
package fcw_pkg;

  localparam int CLUS_W   = 12;
  localparam int SEC_W    = 32;
  localparam int SPC_W    = 8;
  localparam int FADDR_W  = 13;
  localparam int MUL_STEPS = SPC_W;

  typedef logic [1:0] func_t;
  localparam func_t FN_WRITE   = 2'd0;
  localparam func_t FN_START   = 2'd1;
  localparam func_t FN_ADVANCE = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK  = 2'd0;
  localparam status_t ST_END = 2'd1;
  localparam status_t ST_BAD = 2'd2;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t REG_DATA_START = 1'd0;
  localparam cfg_idx_t REG_SPC        = 1'd1;

  localparam logic [CLUS_W-1:0] END_MARK    = 12'hFF8;
  localparam logic [CLUS_W-1:0] FIRST_CLUS  = 12'd2;

  // request to the sector unit: base + (clus - 2) * spc
  typedef struct packed {
    logic              start;
    logic [CLUS_W-1:0] clus;
    logic [SEC_W-1:0]  base;
    logic [SPC_W-1:0]  spc;
  } sec_req_t;

  typedef struct packed {
    logic             done;
    logic [SEC_W-1:0] sector;
  } sec_rsp_t;

endpackage

// ===== rtl/core/fcw_fat_ram.sv =====
// Byte-wide table memory, one write and one registered read port.
module fcw_fat_ram #(
  parameter int DEPTH = 8192,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/fcw_sector_unit.sv =====
// Shift-add sector address unit: base + (clus - 2) * spc, one multiplier bit per cycle.
module fcw_sector_unit (
  input  logic              clk,
  input  logic              rst,
  input  fcw_pkg::sec_req_t req,
  output fcw_pkg::sec_rsp_t rsp
);
  import fcw_pkg::*;

  localparam int CNT_W = $clog2(MUL_STEPS);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [SEC_W-1:0] acc;
  logic [SEC_W-1:0] mcand;
  logic [SPC_W-1:0] mplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc    <= req.base;
      mcand  <= SEC_W'(req.clus - FIRST_CLUS);
      mplier <= req.spc;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  assign rsp.done   = done;
  assign rsp.sector = acc;

endmodule

// ===== rtl/core/fat12_cluster_chain_walker.sv =====
// FAT12 cluster chain walker: table copy, chain state and result register.
// From accept to result beat: writes, unused codes, starts outside the data range and
// advances with no entry to read go straight to S_DONE; advances that end the chain
// first make two byte reads through the one read port of the table memory; data starts
// run the 8-step shift-add sector unit, data advances do both. One item at a time.
// Reset (rst, sync): chain inactive, cluster 0, data start 0, 1 sector per cluster; table kept.
module fat12_cluster_chain_walker #(
  parameter int FAT_BYTES = 8192
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [39:0]               s_tdata,   // fat_addr, fat_byte, start_cluster, zero pad
  input  fcw_pkg::func_t            s_tuser,   // func
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [47:0]               m_tdata,   // cluster, sector_addr, zero pad
  output fcw_pkg::status_t          m_tuser,   // status
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  fcw_pkg::cfg_idx_t         cfg_index,
  input  logic [31:0]               cfg_data
);
  import fcw_pkg::*;

  localparam int AW = $clog2(FAT_BYTES);
  localparam int IW = (AW > FADDR_W) ? AW : FADDR_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD0  = 5'b00010,
    S_RD1  = 5'b00100,
    S_MUL  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [SEC_W-1:0]  data_start;
  logic [SPC_W-1:0]  spc;
  logic [CLUS_W-1:0] cur, cur_next;
  logic              active, active_next;
  logic [CLUS_W-1:0] res_clus, res_clus_next;
  logic [SEC_W-1:0]  res_sec, res_sec_next;
  status_t           res_st, res_st_next;
  logic [7:0]        lo_byte, lo_byte_next;
  logic [FADDR_W-1:0] idx_reg;
  logic              out_load;

  // input beat fields
  logic               s_acc;
  func_t              in_func;
  logic [FADDR_W-1:0] in_addr;
  logic [7:0]         in_byte;
  logic [CLUS_W-1:0]  in_start;

  assign s_acc    = s_tvalid && s_tready;
  assign in_func  = s_tuser;
  assign in_addr  = s_tdata[12:0];
  assign in_byte  = s_tdata[20:13];
  assign in_start = s_tdata[32:21];

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // entry offset = cluster * 3 / 2
  logic [FADDR_W-1:0] idx;
  logic [16:0]        idx_end;
  logic               idx_bad;
  logic               addr_fits;

  assign idx       = FADDR_W'(cur) + FADDR_W'(cur[CLUS_W-1:1]);
  assign idx_end   = 17'(idx) + 17'd1;
  assign idx_bad   = idx_end >= 17'(FAT_BYTES);
  assign addr_fits = 17'(in_addr) < 17'(FAT_BYTES);

  // table memory
  logic          ram_we, ram_re;
  logic [IW-1:0] waddr_w, raddr_w;
  logic [7:0]    ram_rdata;

  assign waddr_w = IW'(in_addr);
  assign raddr_w = (state == S_RD0) ? IW'(idx_reg + FADDR_W'(1)) : IW'(idx);
  assign ram_we  = s_acc && (in_func == FN_WRITE) && addr_fits;
  assign ram_re  = (s_acc && (in_func == FN_ADVANCE) && active && !idx_bad) ||
                   (state == S_RD0);

  fcw_fat_ram #(.DEPTH(FAT_BYTES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr_w[AW-1:0]),
    .wdata (in_byte),
    .re    (ram_re),
    .raddr (raddr_w[AW-1:0]),
    .rdata (ram_rdata)
  );

  // sector unit
  sec_req_t sec_req;
  sec_rsp_t sec_rsp;

  fcw_sector_unit u_sec (
    .clk (clk),
    .rst (rst),
    .req (sec_req),
    .rsp (sec_rsp)
  );

  // next entry, hi byte arrives in S_RD1
  logic [CLUS_W-1:0] next_ent;
  assign next_ent = cur[0] ? {ram_rdata, lo_byte[7:4]} : {ram_rdata[3:0], lo_byte};

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    active_next   = active;
    res_clus_next = res_clus;
    res_sec_next  = res_sec;
    res_st_next   = res_st;
    lo_byte_next  = lo_byte;
    out_load      = 1'b0;
    sec_req.start = 1'b0;
    sec_req.clus  = cur;
    sec_req.base  = data_start;
    sec_req.spc   = spc;
    unique case (state)
      S_IDLE: begin
        if (s_acc) begin
          state_next    = S_DONE;
          res_sec_next  = '0;
          res_clus_next = cur;
          res_st_next   = ST_BAD;
          case (in_func)
            FN_WRITE: begin
              res_st_next = ST_OK;
            end
            FN_START: begin
              cur_next      = in_start;
              res_clus_next = in_start;
              if (in_start < FIRST_CLUS) begin
                active_next = 1'b0;
              end else if (in_start >= END_MARK) begin
                active_next = 1'b0;
                res_st_next = ST_END;
              end else begin
                active_next   = 1'b1;
                res_st_next   = ST_OK;
                sec_req.start = 1'b1;
                sec_req.clus  = in_start;
                state_next    = S_MUL;
              end
            end
            FN_ADVANCE: begin
              if (active) begin
                if (idx_bad) begin
                  active_next = 1'b0;
                end else begin
                  state_next = S_RD0;
                end
              end
            end
            default: begin
              res_st_next = ST_BAD;
            end
          endcase
        end
      end
      S_RD0: begin
        lo_byte_next = ram_rdata;
        state_next   = S_RD1;
      end
      S_RD1: begin
        cur_next      = next_ent;
        res_clus_next = next_ent;
        res_sec_next  = '0;
        if (next_ent >= END_MARK) begin
          active_next = 1'b0;
          res_st_next = ST_END;
          state_next  = S_DONE;
        end else if (next_ent < FIRST_CLUS) begin
          active_next = 1'b0;
          res_st_next = ST_BAD;
          state_next  = S_DONE;
        end else begin
          res_st_next   = ST_OK;
          sec_req.start = 1'b1;
          sec_req.clus  = next_ent;
          state_next    = S_MUL;
        end
      end
      S_MUL: begin
        if (sec_rsp.done) begin
          res_sec_next = sec_rsp.sector;
          state_next   = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur        <= '0;
      active     <= 1'b0;
      m_tvalid   <= 1'b0;
      data_start <= '0;
      spc        <= SPC_W'(1);
    end else begin
      state  <= state_next;
      cur    <= cur_next;
      active <= active_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DATA_START: data_start <= cfg_data;
          REG_SPC:        spc        <= cfg_data[SPC_W-1:0];
          default:        ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    res_clus <= res_clus_next;
    res_sec  <= res_sec_next;
    res_st   <= res_st_next;
    lo_byte  <= lo_byte_next;
    if (s_acc) begin
      idx_reg <= idx;
    end
    if (out_load) begin
      m_tdata <= {4'b0, res_sec, res_clus};
      m_tuser <= res_st;
    end
  end

  // checks
  a_bad_beat_no_sector: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata[43:12] == '0))
    else $error("non-ok result beat carries a sector address");

  a_active_in_range: assert property (@(posedge clk) disable iff (rst)
    active |-> ((cur >= FIRST_CLUS) && (cur < END_MARK)))
    else $error("active chain holds a cluster outside the data range");

  a_mul_needs_chain: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> active)
    else $error("sector computation without an active chain");

  a_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    sec_rsp.done |-> (state == S_MUL))
    else $error("sector unit finished outside the multiply state");

endmodule
